/* rtl/core/arf_pkg.sv */
// Package with shared types and constants of the audio ring FIFO.
`timescale 1ns / 1ps

package arf_pkg;

  // Width of the length, level and threshold fields
  localparam int unsigned FieldW = 13;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STARTUP_LEVEL = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_LEVEL  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_LENGTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REFILL_HIGH   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REFILL_LOW    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REFILL_ENABLE = 3'd5;

  // Reset values of the configuration registers
  localparam logic [FieldW-1:0] RST_STARTUP_LEVEL = 13'd2048;
  localparam logic [FieldW-1:0] RST_TARGET_LEVEL  = 13'd3072;
  localparam logic [FieldW-1:0] RST_BLOCK_LENGTH  = 13'd512;
  localparam logic [FieldW-1:0] RST_REFILL_HIGH   = 13'd544;
  localparam logic [FieldW-1:0] RST_REFILL_LOW    = 13'd528;

  // Request kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
    logic                      first_of_group;
    logic [FieldW-1:0]         batch_length;
  } arf_req_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
    logic                      playing;
    logic                      accepted;
    logic [FieldW-1:0]         level;
    logic [FieldW-1:0]         refill_frames;
  } arf_rsp_t;

endpackage

/* rtl/core/audio_ring_fifo_with_prime_and_underrun.sv */
// Stereo audio ring FIFO with batch push, startup prebuffer and underrun silence.
// The result of an accepted request, strobed by result_valid_o, is registered and appears
// in the next cycle; pulled samples come from the ring memory's registered read port.
// Throughput: one request per cycle; busy stays low, as every request takes at most one
// access of the ring memory and all pointer updates finish in that cycle.
// Reset: pointers, level, batch and block state clear; configuration takes its
// defaults; ring contents stay undefined until written. The receiver cannot stall.
`timescale 1ns / 1ps

module audio_ring_fifo_with_prime_and_underrun #(
  parameter int unsigned RING_FRAMES = 8192
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_we_i,
  input  logic [arf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [arf_pkg::FieldW-1:0]       cfg_data_i,
  input  arf_pkg::arf_req_t                req_i,
  output logic                             result_valid_o,
  output arf_pkg::arf_rsp_t                result_o
);

  import arf_pkg::*;

  localparam int unsigned PW = $clog2(RING_FRAMES);
  localparam int unsigned CW = ((PW > FieldW) ? PW : FieldW) + 1;
  localparam logic [PW-1:0] LAST = PW'(RING_FRAMES - 1);

  // Configuration registers
  logic [FieldW-1:0] startup_q, target_q, block_len_q, refill_high_q, refill_low_q;
  logic              refill_en_q;

  // Ring pointers and committed level
  logic [PW-1:0] wc_q, wc_d, wp_q, wp_d, rc_q, rc_d, rp_q, rp_d, level_q, level_d;
  logic [PW-1:0] free_w;

  // Batch and block state
  logic [FieldW-1:0] push_rem_q, push_rem_d, batch_len_q, batch_len_d;
  logic              push_drop_q, push_drop_d;
  logic [FieldW-1:0] pull_rem_q, pull_rem_d, pull_len_q, pull_len_d;
  logic              block_play_q, block_play_d, started_q, started_d;

  // Push and pull decode
  logic              accept;
  logic [PW-1:0]     p_base, p_next, u_base, u_next;
  logic [FieldW-1:0] p_rem, p_rem_n, p_len, u_rem, u_rem_n, u_len, blen_cfg;
  logic              p_drop, u_play, u_play_first;

  // Ring memory ports
  logic [2*SampleW-1:0] mem [RING_FRAMES];
  logic [2*SampleW-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [PW-1:0]        mem_waddr, mem_raddr;

  // Result registers
  logic              valid_q, out_play_q, out_play_d, out_acc_q, out_acc_d;
  logic [31:0]       level_ext;
  logic [FieldW-1:0] refill_w;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign free_w = LAST - level_q;

  // Hold configuration; ignore indexes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_q     <= RST_STARTUP_LEVEL;
      target_q      <= RST_TARGET_LEVEL;
      block_len_q   <= RST_BLOCK_LENGTH;
      refill_high_q <= RST_REFILL_HIGH;
      refill_low_q  <= RST_REFILL_LOW;
      refill_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STARTUP_LEVEL: startup_q     <= cfg_data_i;
        CFG_TARGET_LEVEL:  target_q      <= cfg_data_i;
        CFG_BLOCK_LENGTH:  block_len_q   <= cfg_data_i;
        CFG_REFILL_HIGH:   refill_high_q <= cfg_data_i;
        CFG_REFILL_LOW:    refill_low_q  <= cfg_data_i;
        CFG_REFILL_ENABLE: refill_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Select batch state: a first frame restarts from the committed write pointer
  always_comb begin
    p_base  = req_i.first_of_group ? wc_q : wp_q;
    p_rem   = req_i.first_of_group ? req_i.batch_length : push_rem_q;
    p_drop  = req_i.first_of_group ? (CW'(req_i.batch_length) > CW'(free_w)) : push_drop_q;
    p_len   = req_i.first_of_group ? req_i.batch_length : batch_len_q;
    p_rem_n = p_rem - FieldW'(1);
    p_next  = (p_base == LAST) ? '0 : p_base + PW'(1);
  end

  // Select block state: a first frame decides play or silence for the block
  always_comb begin
    blen_cfg     = (block_len_q == '0) ? FieldW'(1) : block_len_q;
    u_play_first = (started_q || (CW'(level_q) >= CW'(startup_q)))
                   && (CW'(level_q) >= CW'(blen_cfg));
    u_base  = req_i.first_of_group ? rc_q : rp_q;
    u_rem   = req_i.first_of_group ? blen_cfg : pull_rem_q;
    u_play  = req_i.first_of_group ? u_play_first : block_play_q;
    u_len   = req_i.first_of_group ? blen_cfg : pull_len_q;
    u_rem_n = u_rem - FieldW'(1);
    u_next  = (u_base == LAST) ? '0 : u_base + PW'(1);
  end

  // Update pointers and counters; issue at most one ring access per request
  always_comb begin
    wc_d         = wc_q;
    wp_d         = wp_q;
    rc_d         = rc_q;
    rp_d         = rp_q;
    level_d      = level_q;
    push_rem_d   = push_rem_q;
    batch_len_d  = batch_len_q;
    push_drop_d  = push_drop_q;
    pull_rem_d   = pull_rem_q;
    pull_len_d   = pull_len_q;
    block_play_d = block_play_q;
    started_d    = started_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = p_base;
    mem_raddr    = u_base;
    out_play_d   = 1'b0;
    out_acc_d    = 1'b0;
    if (accept) begin
      if (req_i.kind == KIND_PULL) begin
        if (req_i.first_of_group) begin
          rp_d         = rc_q;
          started_d    = u_play_first;
          block_play_d = u_play_first;
          pull_rem_d   = blen_cfg;
          pull_len_d   = blen_cfg;
        end
        if (u_rem != '0) begin
          pull_rem_d = u_rem_n;
          if (u_play) begin
            mem_re     = 1'b1;
            rp_d       = u_next;
            out_play_d = 1'b1;
            // Commit the read pointer at block end
            if (u_rem_n == '0) begin
              rc_d    = u_next;
              level_d = level_q - PW'(u_len);
            end
          end
          if (u_rem_n == '0) begin
            block_play_d = 1'b0;
          end
        end
      end else begin
        if (req_i.first_of_group) begin
          wp_d        = wc_q;
          push_rem_d  = req_i.batch_length;
          batch_len_d = req_i.batch_length;
          push_drop_d = p_drop;
        end
        if (p_rem != '0) begin
          push_rem_d = p_rem_n;
          if (!p_drop) begin
            mem_we    = 1'b1;
            wp_d      = p_next;
            out_acc_d = 1'b1;
            // Commit the write pointer at batch end
            if (p_rem_n == '0) begin
              wc_d    = p_next;
              level_d = level_q + PW'(p_len);
            end
          end
          if (p_rem_n == '0) begin
            push_drop_d = 1'b0;
          end
        end
      end
    end
  end

  // Hold ring state and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q         <= '0;
      wp_q         <= '0;
      rc_q         <= '0;
      rp_q         <= '0;
      level_q      <= '0;
      push_rem_q   <= '0;
      batch_len_q  <= '0;
      push_drop_q  <= 1'b0;
      pull_rem_q   <= '0;
      pull_len_q   <= '0;
      block_play_q <= 1'b0;
      started_q    <= 1'b0;
      valid_q      <= 1'b0;
      out_play_q   <= 1'b0;
      out_acc_q    <= 1'b0;
    end else begin
      wc_q         <= wc_d;
      wp_q         <= wp_d;
      rc_q         <= rc_d;
      rp_q         <= rp_d;
      level_q      <= level_d;
      push_rem_q   <= push_rem_d;
      batch_len_q  <= batch_len_d;
      push_drop_q  <= push_drop_d;
      pull_rem_q   <= pull_rem_d;
      pull_len_q   <= pull_len_d;
      block_play_q <= block_play_d;
      started_q    <= started_d;
      valid_q      <= accept;
      out_play_q   <= out_play_d;
      out_acc_q    <= out_acc_d;
    end
  end

  // Ring memory: write pushed frames, register pulled frames
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= {req_i.right_in, req_i.left_in};
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Derive the refill request from the committed level
  always_comb begin
    refill_w = '0;
    if (refill_en_q && (CW'(level_q) < CW'(target_q))
        && (CW'(free_w) >= CW'(refill_high_q))) begin
      refill_w = (CW'(level_q) < CW'(startup_q)) ? refill_high_q : refill_low_q;
    end
  end

  // Drive the result; silence when the frame did not come from the ring
  assign level_ext      = 32'(level_q);
  assign result_valid_o = valid_q;
  always_comb begin
    result_o.left_out      = out_play_q ? rdata_q[SampleW-1:0] : '0;
    result_o.right_out     = out_play_q ? rdata_q[2*SampleW-1:SampleW] : '0;
    result_o.playing       = out_play_q;
    result_o.accepted      = out_acc_q;
    result_o.level         = level_ext[FieldW-1:0];
    result_o.refill_frames = refill_w;
  end

`ifndef SYNTHESIS
  // Every request yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("missing result after request");

  // A result never both plays a frame and stores one
  a_play_xor_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(result_o.playing && result_o.accepted))
    else $error("result both played and stored");

  // The level moves only when a pointer is committed
  a_level_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q != $past(level_q)) |-> ((wc_q != $past(wc_q)) || (rc_q != $past(rc_q))))
    else $error("level changed without a commit");

  // A dropping batch never writes the ring
  a_drop_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !p_drop)
    else $error("ring written during a dropped batch");
`endif

endmodule
